// File: src/mbd_pkg.sv
// Shared types, constants and helpers of the 2x2 box-filter downsampler.
`default_nettype none
package mbd_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int PAIRS       = (MAX_WIDTH + 1) / 2;
   localparam int SIZE_W      = 11;
   localparam int POS_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int PAIR_ADDR_W = POS_W - 1;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SINGLE_CHANNEL = 2'd2;

   typedef struct packed {
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] c;
   } pixel_type;

   typedef struct packed {
      logic [8:0] a;
      logic [8:0] b;
      logic [8:0] c;
   } sums_type;

   typedef struct packed {
      logic     odd_row;
      logic     row0;
      logic     frame_end;
      sums_type pair;
   } stage_type;

   typedef struct packed {
      logic                   emit;
      logic                   line_wr;
      logic                   first_wr;
      logic [PAIR_ADDR_W-1:0] addr;
      stage_type              info;
   } step_type;

   // A size of zero counts as one; a size above the maximum saturates.
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] maxv);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: src/mbd_if.sv
// Valid/ready channel interfaces for source pixels and averaged output pixels.
`default_nettype none
interface mbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] chan_a;
   logic [7:0] chan_b;
   logic [7:0] chan_c;

   modport source (output valid, output chan_a, output chan_b, output chan_c,
                   input ready);
   modport sink (input valid, input chan_a, input chan_b, input chan_c,
                 output ready);
endinterface

interface mbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] avg_a;
   logic [7:0] avg_b;
   logic [7:0] avg_c;
   logic       frame_end;

   modport source (output valid, output avg_a, output avg_b, output avg_c,
                   output frame_end, input ready);
   modport sink (input valid, input avg_a, input avg_b, input avg_c,
                 input frame_end, output ready);
endinterface
`default_nettype wire

// File: src/mbd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module mbd_ram #(
   parameter int DEPTH  = 512,
   parameter int WIDTH  = 27,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: src/mbd_pair.sv
// Position counters, horizontal pairing and line-store access decode for one pixel.
`default_nettype none
module mbd_pair (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire logic                      size_write,
   input  wire mbd_pkg::pixel_type        pixel,
   input  wire logic [mbd_pkg::SIZE_W-1:0] image_width,
   input  wire logic [mbd_pkg::SIZE_W-1:0] image_height,
   output      mbd_pkg::step_type         step
);

   logic [mbd_pkg::POS_W-1:0]  col_ff, col_in;
   logic [mbd_pkg::ROW_W-1:0]  row_ff, row_in;
   mbd_pkg::pixel_type         hold_ff, hold_in;
   mbd_pkg::pixel_type         first_ff, first_in;

   logic [mbd_pkg::SIZE_W-1:0] w_eff, h_eff;
   logic [mbd_pkg::POS_W-1:0]  x;
   logic [mbd_pkg::ROW_W-1:0]  y;
   logic                       last_col, last_row, col0, have_pair;
   mbd_pkg::pixel_type         partner;

   assign w_eff = mbd_pkg::clamp_size(image_width, mbd_pkg::SIZE_W'(mbd_pkg::MAX_WIDTH));
   assign h_eff = mbd_pkg::clamp_size(image_height, mbd_pkg::SIZE_W'(mbd_pkg::MAX_HEIGHT));

   always_comb begin
      x = (mbd_pkg::SIZE_W'(col_ff) >= w_eff) ? mbd_pkg::POS_W'(w_eff - 1'b1) : col_ff;
      y = (mbd_pkg::SIZE_W'(row_ff) >= h_eff) ? mbd_pkg::ROW_W'(h_eff - 1'b1) : row_ff;
      last_col  = (mbd_pkg::SIZE_W'(x) == (w_eff - 1'b1));
      last_row  = (mbd_pkg::SIZE_W'(y) == (h_eff - 1'b1));
      col0      = (x == '0);
      have_pair = x[0] || last_col;

      if (x[0]) begin
         partner = hold_ff;
      end else if (col0) begin
         partner = pixel;
      end else begin
         partner = first_ff;
      end

      step.info.pair.a    = {1'b0, partner.a} + {1'b0, pixel.a};
      step.info.pair.b    = {1'b0, partner.b} + {1'b0, pixel.b};
      step.info.pair.c    = {1'b0, partner.c} + {1'b0, pixel.c};
      step.info.odd_row   = y[0];
      step.info.row0      = (y == '0);
      step.info.frame_end = last_col && last_row;
      step.addr           = x[mbd_pkg::POS_W-1:1];
      step.line_wr        = have_pair && !y[0];
      step.first_wr       = have_pair && (y == '0);
      step.emit           = have_pair && (y[0] || last_row);

      col_in   = col_ff;
      row_in   = row_ff;
      hold_in  = hold_ff;
      first_in = first_ff;
      if (size_write) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : y + 1'b1;
         end else begin
            col_in = x + 1'b1;
            row_in = y;
         end
         if (!x[0]) begin
            hold_in = pixel;
         end
         if (col0) begin
            first_in = pixel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff  <= hold_in;
      first_ff <= first_in;
   end

endmodule
`default_nettype wire

// File: src/mbd_out.sv
// Vertical combine of pair sums, truncating average and the output register.
`default_nettype none
module mbd_out (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire mbd_pkg::stage_type info,
   input  wire mbd_pkg::sums_type  line_data,
   input  wire mbd_pkg::sums_type  first_data,
   input  wire logic               single_channel,
   output      logic               take,
   mbd_rsp_if.source               rsp
);

   mbd_pkg::sums_type other;
   logic [9:0]        sum_a, sum_b, sum_c;
   logic              valid_ff, valid_in;
   mbd_pkg::pixel_type avg_ff, avg_in;
   logic              frame_end_ff, frame_end_in;

   always_comb begin
      // On a single-row image row 0 pairs with itself in the same transaction.
      if (info.odd_row) begin
         other = line_data;
      end else if (info.row0) begin
         other = info.pair;
      end else begin
         other = first_data;
      end
      sum_a = {1'b0, info.pair.a} + {1'b0, other.a};
      sum_b = {1'b0, info.pair.b} + {1'b0, other.b};
      sum_c = {1'b0, info.pair.c} + {1'b0, other.c};

      take         = !valid_ff || rsp.ready;
      valid_in     = load ? 1'b1 : (rsp.ready ? 1'b0 : valid_ff);
      avg_in       = avg_ff;
      frame_end_in = frame_end_ff;
      if (load) begin
         avg_in.a     = sum_a[9:2];
         avg_in.b     = single_channel ? 8'd0 : sum_b[9:2];
         avg_in.c     = single_channel ? 8'd0 : sum_c[9:2];
         frame_end_in = info.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      avg_ff       <= avg_in;
      frame_end_ff <= frame_end_in;
   end

   assign rsp.valid     = valid_ff;
   assign rsp.avg_a     = avg_ff.a;
   assign rsp.avg_b     = avg_ff.b;
   assign rsp.avg_c     = avg_ff.c;
   assign rsp.frame_end = frame_end_ff;

endmodule
`default_nettype wire

// File: src/mipmap_box_downsample_2x2.sv
// 2x2 box-filter downsampler: one averaged output pixel per 2x2 block of source pixels.
// A block's result passes the combine-stage and output registers before it appears on rsp.
// Throughput: one source pixel per cycle unless rsp stalls; every pixel reads both stores.
// The registered read of each pixel feeds the vertical add when the combine stage moves.
// Reset clears the position counters and pipeline valids; line stores are not cleared.
`default_nettype none
module mipmap_box_downsample_2x2 (
   input  wire logic                           clock,
   input  wire logic                           reset,
   mbd_req_if.sink                             req,
   mbd_rsp_if.source                           rsp,
   input  wire logic                           csr_wr_en,
   input  wire logic [mbd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mbd_pkg::SIZE_W-1:0]     csr_wr_data
);

   logic [mbd_pkg::SIZE_W-1:0] width_ff, width_in;
   logic [mbd_pkg::SIZE_W-1:0] height_ff, height_in;
   logic                       single_ff, single_in;
   logic                       size_write;

   logic                       accept, out_take, s1_move;
   logic                       s1_valid_ff, s1_valid_in;
   mbd_pkg::stage_type         s1_ff;
   mbd_pkg::pixel_type         pixel;
   mbd_pkg::step_type          step;
   mbd_pkg::sums_type          line_rd, first_rd;

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      single_in  = single_ff;
      size_write = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            mbd_pkg::CSR_IMAGE_WIDTH: begin
               width_in   = csr_wr_data;
               size_write = 1'b1;
            end
            mbd_pkg::CSR_IMAGE_HEIGHT: begin
               height_in  = csr_wr_data;
               size_write = 1'b1;
            end
            mbd_pkg::CSR_SINGLE_CHANNEL: begin
               single_in = csr_wr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mbd_pkg::SIZE_W'(1024);
         height_ff <= mbd_pkg::SIZE_W'(1024);
         single_ff <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         single_ff <= single_in;
      end
   end

   assign pixel.a = req.chan_a;
   assign pixel.b = req.chan_b;
   assign pixel.c = req.chan_c;

   assign s1_move   = s1_valid_ff && out_take;
   assign req.ready = !s1_valid_ff || out_take;
   assign accept    = req.valid && req.ready;

   always_comb begin
      if (accept) begin
         s1_valid_in = step.emit;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= step.info;
      end
   end

   mbd_pair u_pair (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .size_write   (size_write),
      .pixel        (pixel),
      .image_width  (width_ff),
      .image_height (height_ff),
      .step         (step)
   );

   mbd_ram #(
      .DEPTH (mbd_pkg::PAIRS),
      .WIDTH ($bits(mbd_pkg::sums_type))
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (accept && step.line_wr),
      .wr_addr (step.addr),
      .wr_data (step.info.pair),
      .rd_en   (accept),
      .rd_addr (step.addr),
      .rd_data (line_rd)
   );

   mbd_ram #(
      .DEPTH (mbd_pkg::PAIRS),
      .WIDTH ($bits(mbd_pkg::sums_type))
   ) u_first_ram (
      .clock   (clock),
      .wr_en   (accept && step.first_wr),
      .wr_addr (step.addr),
      .wr_data (step.info.pair),
      .rd_en   (accept),
      .rd_addr (step.addr),
      .rd_data (first_rd)
   );

   mbd_out u_out (
      .clock          (clock),
      .reset          (reset),
      .load           (s1_move),
      .info           (s1_ff),
      .line_data      (line_rd),
      .first_data     (first_rd),
      .single_channel (single_ff),
      .take           (out_take),
      .rsp            (rsp)
   );

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp.valid && !rsp.ready) |-> !req.ready)
      else $error("input accepted while the combine stage is blocked");

   a_emit_fills_stage: assert property (@(posedge clock) disable iff (reset)
      (accept && step.emit) |=> s1_valid_ff)
      else $error("emitting transaction did not reach the combine stage");

   a_read_data_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> ($stable(line_rd) && $stable(first_rd)))
      else $error("line-store read data changed while the combine stage waited");

   a_out_loads_on_move: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp.valid)
      else $error("combine stage moved but no result was registered");

endmodule
`default_nettype wire
